FILE: rtl/iee_pkg.sv
// Package for the infix expression evaluator.
// Holds widths, character codes, operator and state enums, and transaction structs.
// No dependencies.
package iee_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [3:0] RADIX      = 4'd10;

    typedef logic [VALUE_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_APPLY  = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               divide_by_zero;
    } result_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
    } div_rsp_t;

    // Sign-extend or truncate a working value to the 32-bit result field.
    function automatic logic [31:0] to_result(word_t v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        return e[31:0];
    endfunction

endpackage

FILE: rtl/iee_div.sv
// Iterative signed divider for the infix expression evaluator, one quotient bit per cycle.
// Truncates toward zero; the divisor must be nonzero.
// Depends on iee_pkg.
module iee_div (
    input  logic             clk,
    input  logic             rst_n,
    input  iee_pkg::div_req_t req,
    output iee_pkg::div_rsp_t rsp
);
    import iee_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    word_t                  quo_reg, quo_next;
    word_t                  mb_reg, mb_next;
    logic                   neg_reg, neg_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   trial;
    logic                   sa, sb;

    always_comb
    begin
        sa        = req.dividend[VALUE_WIDTH-1];
        sb        = req.divisor[VALUE_WIDTH-1];
        rem_shift = {rem_reg[VALUE_WIDTH-1:0], quo_reg[VALUE_WIDTH-1]};
        trial     = rem_shift - {1'b0, mb_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;

        if (busy_reg)
        begin
            // Restoring step: keep the trial remainder when it stays nonnegative.
            if (!trial[VALUE_WIDTH])
            begin
                rem_next = trial;
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = sa ? word_t'(-req.dividend) : req.dividend;
            mb_next   = sb ? word_t'(-req.divisor) : req.divisor;
            neg_next  = sa ^ sb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? word_t'(-quo_reg) : quo_reg;

endmodule

FILE: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: character sequencer and result register.
// Depends on iee_pkg and iee_div.
//
// Usage:
//   The item channel carries one ASCII character per transaction (char_code) and a
//   last_char flag on the final character of an expression. Digits, + - * / are
//   used; every other code is skipped and does not split a number.
//   The result channel carries one transaction per expression: the 32-bit wrapped
//   value and divide_by_zero (value is then 0).
//   Timing: a digit or skipped character is taken in ST_IDLE alone. An operator also
//   passes through ST_APPLY, and through ST_DIVIDE when it closes a division, where
//   the one-bit-per-cycle divider runs. The final character adds one more apply step
//   (plus the divider when a division is pending) and a finish step before the result
//   register loads. item_stall is high while the sequencer is busy.
//   The result sits in a register; the next expression is accepted while it waits,
//   and the finish step holds only if the old result has still not been taken.
//   Reset clears the sum, term, number, error flag and pending operator (add) and
//   drops any held result. After each result the state returns to that reset state.
module infix_expression_evaluator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  iee_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output iee_pkg::result_t  result
);
    import iee_pkg::*;

    state_t   state_reg, state_next;
    word_t    sum_reg, sum_next;
    word_t    term_reg, term_next;
    word_t    num_reg, num_next;
    op_t      pend_reg, pend_next;
    op_t      new_op_reg, new_op_next;
    logic     have_op_reg, have_op_next;
    logic     final_reg, final_next;
    logic     err_reg, err_next;
    logic     rvalid_reg, rvalid_next;
    result_t  result_reg, result_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic     accept;
    logic     is_digit;
    logic     is_op;
    logic     apply_done;
    logic     slot_free;
    op_t      char_op;
    logic [3:0] digit;
    word_t    sum_total;

    iee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign slot_free  = !rvalid_reg || !result_stall;

    always_comb
    begin
        is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
        is_op    = (item.char_code == CHAR_PLUS) || (item.char_code == CHAR_MINUS)
                || (item.char_code == CHAR_STAR) || (item.char_code == CHAR_SLASH);
        digit    = 4'(item.char_code - CHAR_ZERO);
        priority if (item.char_code == CHAR_PLUS)
            char_op = OP_ADD;
        else if (item.char_code == CHAR_MINUS)
            char_op = OP_SUB;
        else if (item.char_code == CHAR_STAR)
            char_op = OP_MUL;
        else
            char_op = OP_DIV;
    end

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        num_next     = num_reg;
        pend_next    = pend_reg;
        new_op_next  = new_op_reg;
        have_op_next = have_op_reg;
        final_next   = final_reg;
        err_next     = err_reg;
        rvalid_next  = rvalid_reg && result_stall;
        result_next  = result_reg;
        apply_done   = 1'b0;
        sum_total    = sum_reg + term_reg;

        div_req.start    = 1'b0;
        div_req.dividend = term_reg;
        div_req.divisor  = num_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    final_next   = item.last_char;
                    have_op_next = is_op;
                    new_op_next  = char_op;
                    if (is_digit)
                        num_next = (num_reg << 3) + (num_reg << 1) + word_t'(digit);
                    if (is_op || item.last_char)
                        state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                unique case (pend_reg)
                    OP_ADD:
                    begin
                        sum_next   = sum_total;
                        term_next  = num_reg;
                        apply_done = 1'b1;
                    end
                    OP_SUB:
                    begin
                        sum_next   = sum_total;
                        term_next  = word_t'(-num_reg);
                        apply_done = 1'b1;
                    end
                    OP_MUL:
                    begin
                        term_next  = word_t'(term_reg * num_reg);
                        apply_done = 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (num_reg == '0)
                        begin
                            err_next   = 1'b1;
                            term_next  = '0;
                            apply_done = 1'b1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = ST_DIVIDE;
                        end
                    end
                    default:
                    begin
                        apply_done = 1'b1;
                    end
                endcase
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    term_next  = div_rsp.quotient;
                    apply_done = 1'b1;
                end
            end
            ST_FINISH:
            begin
                // Hold until the previous result has left the register.
                if (slot_free)
                begin
                    rvalid_next                = 1'b1;
                    result_next.value          = err_reg ? '0 : to_result(sum_total);
                    result_next.divide_by_zero = err_reg;
                    sum_next                   = '0;
                    term_next                  = '0;
                    num_next                   = '0;
                    pend_next                  = OP_ADD;
                    err_next                   = 1'b0;
                    final_next                 = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // After an operand is folded in: advance the operator or finish.
        if (apply_done)
        begin
            num_next = '0;
            if (have_op_reg)
            begin
                pend_next    = new_op_reg;
                have_op_next = 1'b0;
                state_next   = final_reg ? ST_APPLY : ST_IDLE;
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            term_reg    <= '0;
            num_reg     <= '0;
            pend_reg    <= OP_ADD;
            new_op_reg  <= OP_ADD;
            have_op_reg <= 1'b0;
            final_reg   <= 1'b0;
            err_reg     <= 1'b0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            num_reg     <= num_next;
            pend_reg    <= pend_next;
            new_op_reg  <= new_op_next;
            have_op_reg <= have_op_next;
            final_reg   <= final_next;
            err_reg     <= err_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/infix_expression_evaluator_tb.sv
// Testbench for infix_expression_evaluator: feeds character streams and checks every result.
// A scoreboard class predicts each expression value; random idling runs on both channels.
// Depends on iee_pkg and the evaluator RTL.
import iee_pkg::*;

class expr_scoreboard;
    word_t   sum_acc;
    word_t   term_acc;
    word_t   number;
    op_t     op_pending;
    bit      div_zero;
    result_t expected_results[$];
    int      errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        sum_acc    = '0;
        term_acc   = '0;
        number     = '0;
        op_pending = OP_ADD;
        div_zero   = 1'b0;
    endfunction

    // Signed division truncating toward zero, built from magnitudes so that
    // the most negative value divided by -1 wraps to itself.
    function word_t trunc_divide(word_t a, word_t b);
        word_t ma;
        word_t mb;
        word_t q;
        ma = a[VALUE_WIDTH-1] ? -a : a;
        mb = b[VALUE_WIDTH-1] ? -b : b;
        q  = ma / mb;
        return (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) ? -q : q;
    endfunction

    // Combine the number just read with the pending operator.
    function void fold_number();
        case (op_pending)
            OP_ADD:
            begin
                sum_acc  = sum_acc + term_acc;
                term_acc = number;
            end
            OP_SUB:
            begin
                sum_acc  = sum_acc + term_acc;
                term_acc = -number;
            end
            OP_MUL: term_acc = term_acc * number;
            default:
            begin
                if (number == '0)
                begin
                    div_zero = 1'b1;
                    term_acc = '0;
                end
                else
                    term_acc = trunc_divide(term_acc, number);
            end
        endcase
        number = '0;
    endfunction

    function void note_char(item_t it);
        result_t r;
        word_t   total;
        if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE)
            number = number * word_t'(RADIX) + word_t'(it.char_code - CHAR_ZERO);
        else
        begin
            case (it.char_code)
                CHAR_PLUS:
                begin
                    fold_number();
                    op_pending = OP_ADD;
                end
                CHAR_MINUS:
                begin
                    fold_number();
                    op_pending = OP_SUB;
                end
                CHAR_STAR:
                begin
                    fold_number();
                    op_pending = OP_MUL;
                end
                CHAR_SLASH:
                begin
                    fold_number();
                    op_pending = OP_DIV;
                end
                default: ;
            endcase
        end
        if (!it.last_char)
            return;
        fold_number();
        total            = sum_acc + term_acc;
        r.value          = div_zero ? '0 : 32'(signed'(total));
        r.divide_by_zero = div_zero;
        expected_results.push_back(r);
        restart();
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: value %0d divide_by_zero %0b",
                         got.value, got.divide_by_zero);
            return;
        end
        want = expected_results.pop_front();
        if (got.value !== want.value || got.divide_by_zero !== want.divide_by_zero)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected value %0d divide_by_zero %0b, got %0d %0b",
                         want.value, want.divide_by_zero, got.value, got.divide_by_zero);
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module infix_expression_evaluator_tb;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    expr_scoreboard sb = new();
    logic [7:0]     expr_chars[$];
    bit             steady;
    int             counted;

    infix_expression_evaluator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_active(logic [7:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS || c == CHAR_MINUS
            || c == CHAR_STAR || c == CHAR_SLASH;
    endfunction

    function automatic logic [7:0] rand_ignored();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_active(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return CHAR_PLUS;
            1: return CHAR_MINUS;
            2: return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    function automatic int number_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(1, 2);
        if (r < 18)
            return $urandom_range(3, 6);
        return $urandom_range(7, 12);
    endfunction

    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            expr_chars.push_back(8'(s[i]));
    endfunction

    // Digits of a number, now and then split by a character that is skipped.
    function automatic void push_number(int ndig);
        for (int i = 0; i < ndig; i++)
        begin
            expr_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if (i < ndig - 1 && $urandom_range(0, 19) == 0)
                expr_chars.push_back(rand_ignored());
        end
    endfunction

    function automatic void build_expression();
        logic [7:0] op;
        int         nterms;
        expr_chars.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any byte at all
            repeat ($urandom_range(1, 8))
                expr_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) == 0)
            expr_chars.push_back(CHAR_MINUS);
        push_number(number_length());
        nterms = $urandom_range(0, 5);
        for (int t = 0; t < nterms; t++)
        begin
            op = pick_operator();
            expr_chars.push_back(op);
            if ($urandom_range(0, 19) == 0)
                expr_chars.push_back(pick_operator());
            if ($urandom_range(0, 4) == 0)
                expr_chars.push_back(rand_ignored());
            if (t == nterms - 1 && $urandom_range(0, 19) == 0)
                break;
            if (op == CHAR_SLASH && $urandom_range(0, 5) == 0)
                expr_chars.push_back(CHAR_ZERO);
            else if (op == CHAR_SLASH)
                push_number($urandom_range(1, 2));
            else
                push_number(number_length());
        end
        if ($urandom_range(0, 7) == 0)
            expr_chars.push_back(rand_ignored());
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_char(it);
    endtask

    task automatic send_expression();
        item_t it;
        for (int i = 0; i < expr_chars.size(); i++)
        begin
            it.char_code = expr_chars[i];
            it.last_char = (i == expr_chars.size() - 1);
            send_item(it);
            counted++;
        end
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int nexpr;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        counted    = 0;
        steady     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // most negative value divided by -1, both built from wrapped long numbers
        expr_chars.delete();
        push_string("2147483648/4294967295");
        send_expression();
        // leading minus, split number, divide by missing operand, end on skipped bytes
        expr_chars.delete();
        push_string("-1");
        expr_chars.push_back(8'h00);
        push_string("5/");
        expr_chars.push_back(8'hFF);
        send_expression();
        // precedence of multiply over add
        expr_chars.delete();
        push_string("3+4*5");
        send_expression();
        drain();

        nexpr = 0;
        while (counted < 1800)
        begin
            steady = ($urandom_range(0, 5) == 0);
            build_expression();
            send_expression();
            nexpr++;
            if (nexpr % 40 == 0)
                drain();
        end

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int n;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = steady ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            sb.check_result(result);
        end
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
